// ===== sv/mtp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and defaults of the timer pool.
package mtp_pkg;

   localparam int unsigned NUM_TIMERS_DEF = 32;
   localparam int unsigned ADDR_SLOTS     = 32;
   localparam int unsigned SLOT_W         = 5;
   localparam int unsigned CHAN_W         = 4;
   localparam int unsigned DATA_W         = 8;
   localparam int unsigned COUNT_W        = 32;

   localparam logic [2:0] REQ_ALLOC  = 3'd0;
   localparam logic [2:0] REQ_FREE   = 3'd1;
   localparam logic [2:0] REQ_TARGET = 3'd2;
   localparam logic [2:0] REQ_START  = 3'd3;
   localparam logic [2:0] REQ_TICK   = 3'd4;

   localparam logic KIND_ALLOC  = 1'b0;
   localparam logic KIND_EXPIRY = 1'b1;

   typedef enum logic [1:0] {
      ST_FREE  = 2'd0,
      ST_ALLOC = 2'd1,
      ST_RUN   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_FLUSH
   } state_type;

   typedef struct packed {
      logic                 result_kind;
      logic [SLOT_W-1:0]    slot;
      logic                 alloc_ok;
      logic [CHAN_W-1:0]    out_channel;
      logic [DATA_W-1:0]    out_data;
      logic [COUNT_W-1:0]   tick_count;
      logic                 last;
   } result_type;

endpackage

// ===== sv/multi_timer_pool.sv =====
`timescale 1ns / 1ps
// Top level of the countdown timer pool.
//
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_stall  req_type, timer_index, dest_channel,
//                                              event_data, timeout
//  rsp_      out        rsp_valid / rsp_stall  result_kind, slot, alloc_ok, out_channel,
//                                              out_data, tick_count, last
//
// Allocate, free, set target and start are handled in the idle state without leaving it.
// A tick walks every slot through the remaining-count memory with a registered read, one slot
// per cycle unless a stalled result holds the walk; no new transaction is accepted until the
// walk and its flush are done.
// Reset clears all slot status flip-flops at once; no clearing pass is needed.
// A stalled result holds the walk only when a second expiry needs the output register.
module multi_timer_pool #(
   parameter int unsigned NUM_TIMERS = mtp_pkg::NUM_TIMERS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [4:0]  req_timer_index,
   input  logic [3:0]  req_dest_channel,
   input  logic [7:0]  req_event_data,
   input  logic [31:0] req_timeout,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [4:0]  rsp_slot,
   output logic        rsp_alloc_ok,
   output logic [3:0]  rsp_out_channel,
   output logic [7:0]  rsp_out_data,
   output logic [31:0] rsp_tick_count,
   output logic        rsp_last
);
   import mtp_pkg::*;

   localparam int unsigned POOL = (NUM_TIMERS < ADDR_SLOTS) ? NUM_TIMERS : ADDR_SLOTS;
   localparam int unsigned AW   = (POOL > 1) ? $clog2(POOL) : 1;
   localparam int unsigned TW   = CHAN_W + DATA_W;

   state_type          state_ff, state_in;
   status_type         status_ff [POOL];
   status_type         status_in [POOL];
   logic [COUNT_W-1:0] tick_total_ff, tick_total_in;
   logic [AW:0]        rd_cnt_ff, rd_cnt_in;
   logic [AW-1:0]      eval_idx_ff, eval_idx_in;
   logic               eval_v_ff, eval_v_in;
   result_type         pend_ff, pend_in;
   logic               pend_v_ff, pend_v_in;
   result_type         rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               out_free;
   logic               req_acc;
   logic               in_pool;
   logic [AW-1:0]      req_addr;
   logic               eval_run;
   logic               eval_exp;
   logic               walk_hold;
   logic               issue;
   logic               free_found;
   logic [SLOT_W-1:0]  free_idx;

   logic               rem_wr_en;
   logic [AW-1:0]      rem_wr_addr;
   logic [COUNT_W-1:0] rem_wr_data;
   logic [COUNT_W-1:0] rem_rd;
   logic               tgt_wr_en;
   logic [TW-1:0]      tgt_rd;
   result_type         exp_res;

   mtp_ram #(.WIDTH(COUNT_W), .DEPTH(POOL)) u_rem_ram (
      .clock   (clock),
      .wr_en   (rem_wr_en),
      .wr_addr (rem_wr_addr),
      .wr_data (rem_wr_data),
      .rd_en   (issue),
      .rd_addr (rd_cnt_ff[AW-1:0]),
      .rd_data (rem_rd)
   );

   mtp_ram #(.WIDTH(TW), .DEPTH(POOL)) u_tgt_ram (
      .clock   (clock),
      .wr_en   (tgt_wr_en),
      .wr_addr (req_addr),
      .wr_data ({req_dest_channel, req_event_data}),
      .rd_en   (issue),
      .rd_addr (rd_cnt_ff[AW-1:0]),
      .rd_data (tgt_rd)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_free;
   assign req_acc   = req_valid && !req_stall;
   assign in_pool   = {1'b0, req_timer_index} < 6'(POOL);
   assign req_addr  = req_timer_index[AW-1:0];
   assign eval_run  = eval_v_ff && (status_ff[eval_idx_ff] == ST_RUN);
   assign eval_exp  = eval_run && (rem_rd == COUNT_W'(1));
   assign walk_hold = eval_exp && pend_v_ff && !out_free;
   assign issue     = (state_ff == S_WALK) && !walk_hold && (rd_cnt_ff != (AW+1)'(POOL));

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = POOL - 1; i >= 0; i--) begin
         if (status_ff[i] == ST_FREE) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      exp_res             = '0;
      exp_res.result_kind = KIND_EXPIRY;
      exp_res.slot        = SLOT_W'(eval_idx_ff);
      exp_res.out_channel = tgt_rd[TW-1:DATA_W];
      exp_res.out_data    = tgt_rd[DATA_W-1:0];
      exp_res.tick_count  = tick_total_ff;
   end

   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      tick_total_in = tick_total_ff;
      rd_cnt_in     = rd_cnt_ff;
      eval_idx_in   = eval_idx_ff;
      eval_v_in     = 1'b0;
      pend_in       = pend_ff;
      pend_v_in     = pend_v_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rem_wr_en     = 1'b0;
      rem_wr_addr   = req_addr;
      rem_wr_data   = req_timeout;
      tgt_wr_en     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               unique case (req_type)
                  REQ_ALLOC: begin
                     rsp_in             = '0;
                     rsp_in.result_kind = KIND_ALLOC;
                     rsp_in.alloc_ok    = free_found;
                     rsp_in.slot        = free_idx;
                     rsp_in.last        = 1'b1;
                     rsp_valid_in       = 1'b1;
                     if (free_found) begin
                        status_in[free_idx[AW-1:0]] = ST_ALLOC;
                     end
                  end
                  REQ_FREE: begin
                     if (in_pool) begin
                        status_in[req_addr] = ST_FREE;
                     end
                  end
                  REQ_TARGET: begin
                     tgt_wr_en = in_pool;
                  end
                  REQ_START: begin
                     if (in_pool) begin
                        rem_wr_en           = 1'b1;
                        status_in[req_addr] = ST_RUN;
                     end
                  end
                  REQ_TICK: begin
                     tick_total_in = tick_total_ff + COUNT_W'(1);
                     rd_cnt_in     = '0;
                     state_in      = S_WALK;
                  end
                  default: ;
               endcase
            end
         end
         S_WALK: begin
            if (eval_v_ff && !walk_hold) begin
               if (eval_run) begin
                  rem_wr_en   = 1'b1;
                  rem_wr_addr = eval_idx_ff;
                  rem_wr_data = rem_rd - COUNT_W'(1);
               end
               if (eval_exp) begin
                  status_in[eval_idx_ff] = ST_ALLOC;
                  if (pend_v_ff) begin
                     rsp_in       = pend_ff;
                     rsp_in.last  = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
                  pend_in   = exp_res;
                  pend_v_in = 1'b1;
               end
            end
            eval_v_in = (eval_v_ff && walk_hold) || issue;
            if (issue) begin
               eval_idx_in = rd_cnt_ff[AW-1:0];
               rd_cnt_in   = rd_cnt_ff + (AW+1)'(1);
            end
            if (!eval_v_ff && (rd_cnt_ff == (AW+1)'(POOL))) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!pend_v_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_in       = pend_ff;
               rsp_in.last  = 1'b1;
               rsp_valid_in = 1'b1;
               pend_v_in    = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tick_total_ff <= '0;
         rd_cnt_ff     <= '0;
         eval_v_ff     <= 1'b0;
         pend_v_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < POOL; i++) begin
            status_ff[i] <= ST_FREE;
         end
      end else begin
         state_ff      <= state_in;
         tick_total_ff <= tick_total_in;
         rd_cnt_ff     <= rd_cnt_in;
         eval_v_ff     <= eval_v_in;
         pend_v_ff     <= pend_v_in;
         rsp_valid_ff  <= rsp_valid_in;
         status_ff     <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff <= eval_idx_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_ff.result_kind;
   assign rsp_slot        = rsp_ff.slot;
   assign rsp_alloc_ok    = rsp_ff.alloc_ok;
   assign rsp_out_channel = rsp_ff.out_channel;
   assign rsp_out_data    = rsp_ff.out_data;
   assign rsp_tick_count  = rsp_ff.tick_count;
   assign rsp_last        = rsp_ff.last;

endmodule

// ===== sv/mtp_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module mtp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/mtp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the timer pool and its bind to the top level.
module mtp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_result_kind,
   input logic [4:0]  rsp_slot,
   input logic        rsp_alloc_ok,
   input logic [3:0]  rsp_out_channel,
   input logic [7:0]  rsp_out_data,
   input logic [31:0] rsp_tick_count,
   input logic        rsp_last
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_last)
         && $stable(rsp_result_kind) && $stable(rsp_tick_count) && $stable(rsp_alloc_ok)
         && $stable(rsp_out_channel) && $stable(rsp_out_data))
      else $error("stalled result changed");

   a_alloc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_kind |-> rsp_last && rsp_tick_count == 32'd0)
      else $error("allocation reply not final or carries a count");

   a_alloc_fail_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_kind && !rsp_alloc_ok |-> rsp_slot == 5'd0)
      else $error("failed allocation reports a slot");

   a_expiry_no_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind |-> !rsp_alloc_ok)
      else $error("expiry flagged as allocation");

endmodule

bind multi_timer_pool mtp_checker u_mtp_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the timer pool: directed table, then random traffic vs a shadow pool.
module tb_top;
   import mtp_pkg::*;

   localparam int unsigned POOL         = 32;
   localparam int unsigned HOLD_LEN     = 300;
   localparam int unsigned DRAIN_CYCLES = 64;
   localparam int unsigned LIMIT_NS     = 1_000_000;
   localparam logic [2:0]  REQ_UNDEF_FIRST = 3'd5;
   localparam logic [2:0]  REQ_UNDEF_LAST  = 3'd7;

   typedef struct packed {
      logic [2:0]  op;
      logic [4:0]  index;
      logic [3:0]  chan;
      logic [7:0]  data;
      logic [31:0] tmo;
   } request_type;

   typedef struct packed {
      request_type rq;
      logic        typed;
      logic [4:0]  grant;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_type;
   logic [4:0]  req_timer_index;
   logic [3:0]  req_dest_channel;
   logic [7:0]  req_event_data;
   logic [31:0] req_timeout;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_result_kind;
   logic [4:0]  rsp_slot;
   logic        rsp_alloc_ok;
   logic [3:0]  rsp_out_channel;
   logic [7:0]  rsp_out_data;
   logic [31:0] rsp_tick_count;
   logic        rsp_last;

   status_type  slot_state [POOL];
   logic [31:0] count_left [POOL];
   logic [3:0]  chan_of [POOL];
   logic [7:0]  data_of [POOL];
   bit          target_known [POOL];
   logic [31:0] ticks_seen;
   logic [4:0]  grant_slot;
   logic        grant_ok;
   result_type  due_results [$];
   row_type     directed_rows [$];

   int unsigned items_sent = 0;
   int unsigned mismatch_count = 0;
   int unsigned send_idle_pct = 7;
   int unsigned recv_idle_pct = 53;
   int unsigned hold_asked = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;

   multi_timer_pool DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_timer_index  (req_timer_index),
      .req_dest_channel (req_dest_channel),
      .req_event_data   (req_event_data),
      .req_timeout      (req_timeout),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_slot         (rsp_slot),
      .rsp_alloc_ok     (rsp_alloc_ok),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_out_data     (rsp_out_data),
      .rsp_tick_count   (rsp_tick_count),
      .rsp_last         (rsp_last)
   );

   always #1 clock = ~clock;

   function automatic request_type make_req(input logic [2:0] op, input int unsigned idx,
                                            input int unsigned chan, input int unsigned data,
                                            input logic [31:0] tmo);
      request_type rq;
      rq.op    = op;
      rq.index = 5'(idx);
      rq.chan  = 4'(chan);
      rq.data  = 8'(data);
      rq.tmo   = tmo;
      return rq;
   endfunction

   function automatic void apply_request(input request_type rq);
      result_type r;
      int unsigned first;
      r = '0;
      first = due_results.size();
      case (rq.op)
         REQ_ALLOC: begin
            r.result_kind = KIND_ALLOC;
            r.last = 1'b1;
            grant_ok = 1'b0;
            for (int i = 0; i < POOL; i++) begin
               if (!grant_ok && slot_state[i] == ST_FREE) begin
                  slot_state[i] = ST_ALLOC;
                  grant_ok = 1'b1;
                  r.slot = 5'(i);
               end
            end
            r.alloc_ok = grant_ok;
            grant_slot = r.slot;
            due_results.push_back(r);
         end
         REQ_FREE: slot_state[rq.index] = ST_FREE;
         REQ_TARGET: begin
            chan_of[rq.index] = rq.chan;
            data_of[rq.index] = rq.data;
            target_known[rq.index] = 1'b1;
         end
         REQ_START: begin
            count_left[rq.index] = rq.tmo;
            slot_state[rq.index] = ST_RUN;
         end
         REQ_TICK: begin
            ticks_seen = ticks_seen + 32'd1;
            for (int i = 0; i < POOL; i++) begin
               if (slot_state[i] == ST_RUN) begin
                  count_left[i] = count_left[i] - 32'd1;
                  if (count_left[i] == 32'd0) begin
                     slot_state[i] = ST_ALLOC;
                     r = '0;
                     r.result_kind = KIND_EXPIRY;
                     r.slot = 5'(i);
                     r.out_channel = chan_of[i];
                     r.out_data = data_of[i];
                     r.tick_count = ticks_seen;
                     due_results.push_back(r);
                  end
               end
            end
            if (due_results.size() > first) begin
               r = due_results.pop_back();
               r.last = 1'b1;
               due_results.push_back(r);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic string show(input result_type r);
      return $sformatf("kind=%0d slot=%0d ok=%0d chan=%0d data=%02h count=%0d last=%0d",
                       r.result_kind, r.slot, r.alloc_ok, r.out_channel, r.out_data,
                       r.tick_count, r.last);
   endfunction

   function automatic void check_result();
      result_type got;
      result_type want;
      got.result_kind = rsp_result_kind;
      got.slot        = rsp_slot;
      got.alloc_ok    = rsp_alloc_ok;
      got.out_channel = rsp_out_channel;
      got.out_data    = rsp_out_data;
      got.tick_count  = rsp_tick_count;
      got.last        = rsp_last;
      if (due_results.size() == 0) begin
         mismatch_count++;
         $display("%0t: unexpected transaction, expected none, actual %s", $time, show(got));
         return;
      end
      want = due_results.pop_front();
      if (got.result_kind !== want.result_kind || got.slot !== want.slot ||
          got.alloc_ok !== want.alloc_ok || got.out_channel !== want.out_channel ||
          got.out_data !== want.out_data || got.tick_count !== want.tick_count ||
          got.last !== want.last) begin
         mismatch_count++;
         $display("%0t: expected %s, actual %s", $time, show(want), show(got));
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_result();
         if (hold_left == 0 && hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic issue(input request_type rq, input bit typed = 1'b0,
                        input logic [4:0] typed_slot = '0);
      result_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      apply_request(rq);
      if (typed) begin
         want = '0;
         want.result_kind = KIND_ALLOC;
         want.slot = typed_slot;
         want.alloc_ok = 1'b1;
         want.last = 1'b1;
         void'(due_results.pop_back());
         due_results.push_back(want);
      end
      if (rq.op <= REQ_TICK)
         items_sent++;
      req_valid        <= 1'b1;
      req_type         <= rq.op;
      req_timer_index  <= rq.index;
      req_dest_channel <= rq.chan;
      req_event_data   <= rq.data;
      req_timeout      <= rq.tmo;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic send_tick();
      issue(make_req(REQ_TICK, $urandom_range(31), $urandom_range(15), $urandom_range(255),
                     $urandom));
   endtask

   task automatic set_target(input int unsigned idx);
      issue(make_req(REQ_TARGET, idx, $urandom_range(15), $urandom_range(255), $urandom));
   endtask

   task automatic timer_life();
      issue(make_req(REQ_ALLOC, $urandom_range(31), $urandom_range(15), $urandom_range(255),
                     $urandom));
      if (grant_ok) begin
         set_target(grant_slot);
         issue(make_req(REQ_START, grant_slot, $urandom_range(15), $urandom_range(255),
                        $urandom_range(1, 5)));
         repeat ($urandom_range(3))
            send_tick();
      end
   endtask

   task automatic stray_request();
      logic [2:0]  op;
      int unsigned idx;
      logic [31:0] tmo;
      op = 3'($urandom_range(REQ_UNDEF_LAST));
      idx = $urandom_range(31);
      case ($urandom_range(7))
         0: tmo = '0;
         1, 2: tmo = $urandom;
         default: tmo = $urandom_range(1, 6);
      endcase
      if (op == REQ_START && !target_known[idx])
         set_target(idx);
      issue(make_req(op, idx, $urandom_range(15), $urandom_range(255), tmo));
   endtask

   task automatic expire_all();
      for (int i = 0; i < POOL; i++) begin
         if ($urandom_range(1) == 1 || !target_known[i])
            set_target(i);
         issue(make_req(REQ_START, i, $urandom_range(15), $urandom_range(255), 32'd1));
      end
      send_tick();
      send_tick();
   endtask

   task automatic drain_pool();
      repeat (POOL + 2)
         issue(make_req(REQ_ALLOC, $urandom_range(31), $urandom_range(15),
                        $urandom_range(255), $urandom));
      repeat ($urandom_range(8, 16))
         issue(make_req(REQ_FREE, $urandom_range(31), $urandom_range(15),
                        $urandom_range(255), $urandom));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (due_results.size() != 0);
   endtask

   task automatic random_traffic(input int unsigned stop_at);
      int unsigned pick;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 50)
            timer_life();
         else if (pick < 70)
            repeat ($urandom_range(1, 3)) send_tick();
         else if (pick < 97)
            stray_request();
         else if (pick < 98)
            expire_all();
         else
            drain_pool();
      end
   endtask

   task automatic add_row(input request_type rq, input bit typed = 1'b0,
                          input logic [4:0] grant = '0);
      row_type row;
      row.rq = rq;
      row.typed = typed;
      row.grant = grant;
      directed_rows.push_back(row);
   endtask

   initial begin
      req_valid        <= 1'b0;
      req_type         <= REQ_ALLOC;
      req_timer_index  <= '0;
      req_dest_channel <= '0;
      req_event_data   <= '0;
      req_timeout      <= '0;
      ticks_seen = '0;
      for (int i = 0; i < POOL; i++) begin
         slot_state[i] = ST_FREE;
         target_known[i] = 1'b0;
      end

      add_row(make_req(REQ_ALLOC, 0, 0, 0, '0), 1'b1, 5'd0);
      add_row(make_req(REQ_ALLOC, 31, 15, 255, '1), 1'b1, 5'd1);
      add_row(make_req(REQ_UNDEF_FIRST, 0, 0, 0, '0));
      add_row(make_req(REQ_UNDEF_LAST, 31, 15, 255, '1));
      add_row(make_req(REQ_TICK, 0, 0, 0, '0));
      add_row(make_req(REQ_TARGET, 0, 15, 255, '1));
      add_row(make_req(REQ_START, 0, 0, 0, 32'd1));
      add_row(make_req(REQ_TARGET, 31, 0, 0, '0));
      add_row(make_req(REQ_START, 31, 15, 255, 32'd2));
      add_row(make_req(REQ_TARGET, 1, 10, 8'h5a, 32'h5a5a_a5a5));
      add_row(make_req(REQ_START, 1, 5, 8'ha5, 32'd1));
      add_row(make_req(REQ_TICK, 31, 15, 255, '1));
      add_row(make_req(REQ_TICK, 0, 0, 0, '0));
      add_row(make_req(REQ_ALLOC, 0, 0, 0, '0), 1'b1, 5'd2);
      add_row(make_req(REQ_FREE, 0, 0, 0, '0));
      add_row(make_req(REQ_ALLOC, 0, 0, 0, '0), 1'b1, 5'd0);
      add_row(make_req(REQ_TARGET, 2, 3, 8'h81, '0));
      add_row(make_req(REQ_START, 2, 0, 0, '0));
      add_row(make_req(REQ_TICK, 0, 0, 0, '0));
      add_row(make_req(REQ_START, 2, 0, 0, '1));
      add_row(make_req(REQ_FREE, 31, 0, 0, '0));
      add_row(make_req(REQ_FREE, 2, 0, 0, '0));
      add_row(make_req(REQ_ALLOC, 0, 0, 0, '0), 1'b1, 5'd2);
      add_row(make_req(REQ_UNDEF_FIRST + 3'd1, 17, 6, 8'h3c, 32'hdead_beef));
      add_row(make_req(REQ_TICK, 0, 0, 0, '0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         issue(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].grant);
      settle();

      expire_all();
      random_traffic(160);
      settle();

      send_idle_pct = 53;
      recv_idle_pct = 7;
      drain_pool();
      random_traffic(300);
      settle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_asked++;
      drain_pool();
      random_traffic(430);
      settle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #(LIMIT_NS);
      $display("%0t: watchdog expired with %0d transactions outstanding", $time,
               due_results.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/mtp_pkg.sv
sv/mtp_ram.sv
sv/multi_timer_pool.sv
sv/mtp_checker.sv
tb/tb_top.sv
